[rtl/hill27_pkg.sv]
// Package for the 3x3 Hill cipher over a 27-symbol alphabet.
// Holds the code type, register indexes, the inverse state encoding and the
// mod 27 helpers. It has no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package hill27_pkg;

  localparam int unsigned MODULUS = 27;
  localparam int unsigned KEY_W = 45;
  localparam int unsigned KEY_ENTRIES = 9;
  localparam int unsigned BLOCK_LEN = 3;
  localparam int unsigned SUM_W = 12;
  localparam int unsigned PROD_W = 10;
  localparam int unsigned RAW_W = 11;

  localparam logic [KEY_W-1:0] KEY_RESET = 45'd10177165265985;

  localparam logic [4:0] PAD_CODE = 5'd24;
  localparam logic [4:0] NEG_ONE = 5'd26;
  localparam logic [7:0] CHAR_SPACE = 8'd32;
  localparam logic [7:0] CHAR_UPPER_A = 8'd65;
  localparam logic [7:0] CHAR_UPPER_Z = 8'd90;
  localparam logic [7:0] CHAR_LOWER_A = 8'd97;
  localparam logic [7:0] CHAR_LOWER_Z = 8'd122;
  localparam logic [7:0] UPPER_BASE = 8'd64;
  localparam logic [7:0] LOWER_BASE = 8'd96;

  // Reciprocal of 27 scaled by 2^18; exact quotient for any 12-bit value.
  localparam logic [13:0] RECIP27 = 14'd9710;
  localparam int unsigned RECIP_SHIFT = 18;

  // Bias that makes every signed cofactor non-negative; a multiple of 27.
  localparam logic signed [SUM_W-1:0] COF_BIAS = 12'sd972;

  typedef logic [4:0] code_t;

  typedef enum logic {
    REG_KEY  = 1'b0,
    REG_MODE = 1'b1
  } cfg_reg_t;

  typedef enum logic [2:0] {
    INV_IDLE,
    INV_COF,
    INV_COFMOD,
    INV_DET,
    INV_DETMOD,
    INV_SCALE,
    INV_FINAL
  } inv_state_t;

  typedef struct packed {
    logic  ok;
    code_t code;
  } char_class_t;

  // Cofactor i equals key[IDX[i][0]]*key[IDX[i][1]] - key[IDX[i][2]]*key[IDX[i][3]],
  // with the sign of the odd positions already folded into the operand order.
  localparam logic [3:0] COF_IDX [KEY_ENTRIES][4] = '{
    '{4'd4, 4'd8, 4'd5, 4'd7},
    '{4'd2, 4'd7, 4'd1, 4'd8},
    '{4'd1, 4'd5, 4'd2, 4'd4},
    '{4'd5, 4'd6, 4'd3, 4'd8},
    '{4'd0, 4'd8, 4'd2, 4'd6},
    '{4'd2, 4'd3, 4'd0, 4'd5},
    '{4'd3, 4'd7, 4'd4, 4'd6},
    '{4'd1, 4'd6, 4'd0, 4'd7},
    '{4'd0, 4'd4, 4'd1, 4'd3}
  };

  function automatic code_t mod27(input logic [SUM_W-1:0] x);
    logic [25:0] prod;
    logic [7:0] quo;
    logic [SUM_W-1:0] rem;
    prod = 26'(x) * 26'(RECIP27);
    quo = 8'(prod >> RECIP_SHIFT);
    rem = x - 12'(16'(quo) * 16'd27);
    if (rem >= 12'd27) begin
      rem = rem - 12'd27;
    end
    return 5'(rem);
  endfunction

  // Multiplicative inverse mod 27; zero when none exists.
  function automatic code_t inv27(input code_t d);
    code_t r;
    unique case (d)
      5'd1:    r = 5'd1;
      5'd2:    r = 5'd14;
      5'd4:    r = 5'd7;
      5'd5:    r = 5'd11;
      5'd7:    r = 5'd4;
      5'd8:    r = 5'd17;
      5'd10:   r = 5'd19;
      5'd11:   r = 5'd5;
      5'd13:   r = 5'd25;
      5'd14:   r = 5'd2;
      5'd16:   r = 5'd22;
      5'd17:   r = 5'd8;
      5'd19:   r = 5'd10;
      5'd20:   r = 5'd23;
      5'd22:   r = 5'd16;
      5'd23:   r = 5'd20;
      5'd25:   r = 5'd13;
      5'd26:   r = 5'd26;
      default: r = 5'd0;
    endcase
    return r;
  endfunction

  function automatic char_class_t classify(input logic [7:0] b);
    char_class_t c;
    c.ok = 1'b1;
    c.code = 5'd0;
    if (b == CHAR_SPACE) begin
      c.code = 5'd0;
    end else if (b >= CHAR_UPPER_A && b <= CHAR_UPPER_Z) begin
      c.code = 5'(b - UPPER_BASE);
    end else if (b >= CHAR_LOWER_A && b <= CHAR_LOWER_Z) begin
      c.code = 5'(b - LOWER_BASE);
    end else begin
      c.ok = 1'b0;
    end
    return c;
  endfunction

  function automatic logic [7:0] code_to_char(input code_t code);
    return (code == 5'd0) ? CHAR_SPACE : (UPPER_BASE + 8'(code));
  endfunction

endpackage

`default_nettype wire

[rtl/hill_cipher_3x3_mod27.sv]
// Top level of the 3x3 Hill cipher over space and A to Z, modulus 27.
// Depends on hill27_pkg for types, constants and the mod 27 helpers.
// ------------------------------------------------------------------
//  Channel   Handshake              Payload
//  in        in_valid / in_ready    text_byte, end_of_message
//  out       out_valid / out_ready  out_char, last_of_message, key_invalid
//  cfg       cfg_valid / cfg_ready  cfg_index, cfg_data
// ------------------------------------------------------------------
// One request is taken per cycle while in_ready is high; a block enters a
// three-stage path (block register, product sums, result buffer) and leaves
// one character per cycle while out_ready is high.
// After reset and after each key write a sequencer builds the inverse key;
// neither in_ready nor cfg_ready is high during it.
// A stall on out_ready backs up through the stages to in_ready.
`timescale 1ns / 1ps
`default_nettype none

module hill_cipher_3x3_mod27 (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire logic [7:0]                   text_byte,
  input  wire logic                         end_of_message,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output logic [7:0]                        out_char,
  output logic                              last_of_message,
  output logic                              key_invalid,
  input  wire logic                         cfg_valid,
  output logic                              cfg_ready,
  input  wire hill27_pkg::cfg_reg_t         cfg_index,
  input  wire logic [hill27_pkg::KEY_W-1:0] cfg_data
);

  import hill27_pkg::*;

  // Configuration and inverse key.
  logic [KEY_W-1:0] key_matrix;
  logic             decrypt_mode;
  code_t            key_ent [KEY_ENTRIES];
  code_t            inverse_matrix [KEY_ENTRIES];
  logic             inverse_missing;

  inv_state_t                inv_state;
  inv_state_t                inv_state_next;
  logic                      inv_idle;
  logic signed [RAW_W-1:0]   cof_raw [KEY_ENTRIES];
  code_t                     cof [KEY_ENTRIES];
  logic [SUM_W-1:0]          det_sum;
  code_t                     det;
  logic [PROD_W-1:0]         inv_raw [KEY_ENTRIES];
  code_t                     det_inv;

  logic cfg_fire;

  // Input side.
  char_class_t      cls;
  code_t            held_codes [2];
  logic [1:0]       held_count;
  code_t            h0_next;
  code_t            h1_next;
  logic [1:0]       held_count_next;
  logic             blk_valid;
  logic             blk_last;
  code_t            blk_vec [BLOCK_LEN];
  logic             in_fire;

  // Pipeline stages.
  logic             a_valid;
  logic             a_last;
  code_t            a_vec [BLOCK_LEN];
  logic             a_ready;
  logic             s_valid;
  logic             s_last;
  logic [SUM_W-1:0] s_sum [BLOCK_LEN];
  logic             s_ready;
  code_t            mat [KEY_ENTRIES];
  logic [SUM_W-1:0] sum_next [BLOCK_LEN];
  code_t            b_codes [BLOCK_LEN];
  logic [1:0]       b_count;
  logic             b_last;
  logic             b_load;
  logic             out_fire;

  always_comb begin
    for (int n = 0; n < KEY_ENTRIES; n++) begin
      key_ent[n] = key_matrix[5*n +: 5];
    end
  end

  assign cfg_fire = cfg_valid && cfg_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      key_matrix <= KEY_RESET;
      decrypt_mode <= 1'b0;
    end else if (cfg_fire) begin
      unique case (cfg_index)
        REG_KEY:  key_matrix <= cfg_data;
        REG_MODE: decrypt_mode <= cfg_data[0];
      endcase
    end
  end

  // Inverse key sequencer.
  always_comb begin
    inv_state_next = inv_state;
    unique case (inv_state)
      INV_IDLE: begin
        if (cfg_fire && cfg_index == REG_KEY) begin
          inv_state_next = INV_COF;
        end
      end
      INV_COF:    inv_state_next = INV_COFMOD;
      INV_COFMOD: inv_state_next = INV_DET;
      INV_DET:    inv_state_next = INV_DETMOD;
      INV_DETMOD: inv_state_next = INV_SCALE;
      INV_SCALE:  inv_state_next = INV_FINAL;
      INV_FINAL:  inv_state_next = INV_IDLE;
      default:    inv_state_next = INV_IDLE;
    endcase
  end

  always_comb begin
    inv_idle = (inv_state == INV_IDLE);
    cfg_ready = inv_idle;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      inv_state <= INV_COF;
    end else begin
      inv_state <= inv_state_next;
    end
  end

  assign det_inv = inv27(det);

  always_ff @(posedge clk) begin
    if (rst) begin
      inverse_missing <= 1'b0;
    end else if (inv_state == INV_SCALE) begin
      inverse_missing <= (det_inv == 5'd0);
    end
  end

  always_ff @(posedge clk) begin
    unique case (inv_state)
      INV_COF: begin
        for (int i = 0; i < KEY_ENTRIES; i++) begin
          cof_raw[i] <= $signed({1'b0, PROD_W'(key_ent[COF_IDX[i][0]] * key_ent[COF_IDX[i][1]])})
                      - $signed({1'b0, PROD_W'(key_ent[COF_IDX[i][2]] * key_ent[COF_IDX[i][3]])});
        end
      end
      INV_COFMOD: begin
        for (int i = 0; i < KEY_ENTRIES; i++) begin
          cof[i] <= mod27(SUM_W'(SUM_W'(cof_raw[i]) + COF_BIAS));
        end
      end
      INV_DET: begin
        det_sum <= SUM_W'(key_ent[0] * cof[0]) + SUM_W'(key_ent[1] * cof[3])
                 + SUM_W'(key_ent[2] * cof[6]);
      end
      INV_DETMOD: begin
        det <= mod27(det_sum);
      end
      INV_SCALE: begin
        for (int i = 0; i < KEY_ENTRIES; i++) begin
          inv_raw[i] <= PROD_W'(cof[i] * ((det_inv == 5'd0) ? NEG_ONE : det_inv));
        end
      end
      INV_FINAL: begin
        for (int i = 0; i < KEY_ENTRIES; i++) begin
          inverse_matrix[i] <= mod27(SUM_W'(inv_raw[i]));
        end
      end
      default: begin
      end
    endcase
  end

  // Block assembly from the incoming byte and the held codes.
  always_comb begin
    cls = classify(text_byte);
    blk_valid = 1'b0;
    blk_last = end_of_message;
    h0_next = held_codes[0];
    h1_next = held_codes[1];
    held_count_next = held_count;
    blk_vec = '{held_codes[0], held_codes[1], cls.code};
    if (cls.ok && held_count == 2'd2) begin
      blk_valid = 1'b1;
      held_count_next = 2'd0;
    end else begin
      if (cls.ok) begin
        if (held_count == 2'd0) begin
          h0_next = cls.code;
        end else begin
          h1_next = cls.code;
        end
        held_count_next = held_count + 2'd1;
      end
      if (end_of_message && held_count_next != 2'd0) begin
        blk_valid = 1'b1;
        blk_last = 1'b1;
        blk_vec = '{h0_next, (held_count_next == 2'd2) ? h1_next : PAD_CODE, PAD_CODE};
      end
      if (end_of_message) begin
        held_count_next = 2'd0;
      end
    end
  end

  assign out_valid = (b_count != 2'd0);
  assign out_fire = out_valid && out_ready;
  assign b_load = (b_count == 2'd0) || (b_count == 2'd1 && out_ready);
  assign s_ready = !s_valid || b_load;
  assign a_ready = !a_valid || s_ready;
  assign in_ready = a_ready && inv_idle;
  assign in_fire = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_count <= 2'd0;
    end else if (in_fire) begin
      held_count <= held_count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      held_codes[0] <= h0_next;
      held_codes[1] <= h1_next;
    end
  end

  // Block register.
  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (a_ready) begin
      a_valid <= in_fire && blk_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (a_ready) begin
      a_vec <= blk_vec;
      a_last <= blk_last;
    end
  end

  // Product sums.
  always_comb begin
    for (int n = 0; n < KEY_ENTRIES; n++) begin
      mat[n] = decrypt_mode ? inverse_matrix[n] : key_ent[n];
    end
    for (int i = 0; i < BLOCK_LEN; i++) begin
      sum_next[i] = SUM_W'(mat[3*i] * a_vec[0]) + SUM_W'(mat[3*i+1] * a_vec[1])
                  + SUM_W'(mat[3*i+2] * a_vec[2]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s_valid <= 1'b0;
    end else if (s_ready) begin
      s_valid <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_ready) begin
      s_sum <= sum_next;
      s_last <= a_last;
    end
  end

  // Result buffer, shifted out one character at a time.
  always_ff @(posedge clk) begin
    if (rst) begin
      b_count <= 2'd0;
    end else if (b_load) begin
      b_count <= s_valid ? 2'd3 : 2'd0;
    end else if (out_fire) begin
      b_count <= b_count - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (b_load) begin
      for (int i = 0; i < BLOCK_LEN; i++) begin
        b_codes[i] <= mod27(s_sum[i]);
      end
      b_last <= s_last;
    end else if (out_fire) begin
      b_codes[0] <= b_codes[1];
      b_codes[1] <= b_codes[2];
    end
  end

  assign out_char = code_to_char(b_codes[0]);
  assign last_of_message = b_last && (b_count == 2'd1);
  assign key_invalid = inverse_missing;

  a_eom_clears_held: assert property (@(posedge clk) disable iff (rst)
    in_fire && end_of_message |=> held_count == 2'd0)
    else $error("held codes remain after end of message");

  a_held_range: assert property (@(posedge clk) disable iff (rst)
    held_count != 2'd3)
    else $error("held count out of range");

  a_buffer_fill: assert property (@(posedge clk) disable iff (rst)
    b_load && s_valid |=> b_count == 2'd3)
    else $error("result buffer did not take a full block");

  a_key_busy: assert property (@(posedge clk) disable iff (rst)
    cfg_fire && cfg_index == REG_KEY |=> !cfg_ready && !in_ready)
    else $error("requests taken while the inverse key is built");

endmodule

`default_nettype wire

[tb/sv/tb_hill_cipher_3x3_mod27.sv]
// Self-checking testbench for the 3x3 mod 27 Hill cipher top level.
// Holds the character tracker class that predicts each cipher block, the tasks that
// drive the text and register channels, and out_ready stalls. Depends on hill27_pkg.
`timescale 1ns / 1ps

module tb_hill_cipher_3x3_mod27;
  import hill27_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned SETTLE_CYCLES = 12;
  localparam int unsigned PHASE_ITEMS = 36;
  localparam int unsigned RANDOM_PHASES = 8;
  localparam logic [KEY_W-1:0] KEY_ALL_ONES = {KEY_W{1'b1}};

  typedef struct {
    logic [7:0] ch;
    logic       last;
    logic       bad_key;
  } cipher_char_t;

  class cipher_tracker;
    logic [KEY_W-1:0] key;
    logic             decrypt;
    logic [4:0]       inv_key[9];
    logic             inv_missing;
    logic [4:0]       held[2];
    int               held_n;
    cipher_char_t     expected_chars[$];
    int               fail_count;

    function new();
      key = KEY_RESET;
      decrypt = 1'b0;
      held_n = 0;
      held[0] = '0;
      held[1] = '0;
      fail_count = 0;
      rebuild_inverse();
    endfunction

    function int letter_code(logic [7:0] b);
      if (b == 8'd32) return 0;
      if (b >= 8'd65 && b <= 8'd90) return int'(b) - 64;
      if (b >= 8'd97 && b <= 8'd122) return int'(b) - 96;
      return -1;
    endfunction

    function int entry(int n);
      return int'(key[5*n +: 5]);
    endfunction

    function int wrap27(int x);
      int r;
      r = x % 27;
      if (r < 0) r += 27;
      return r;
    endfunction

    function void rebuild_inverse();
      int a[9];
      int c[9];
      int det;
      int dinv;
      for (int i = 0; i < 9; i++) a[i] = entry(i);
      c[0] = a[4] * a[8] - a[5] * a[7];
      c[1] = -(a[1] * a[8] - a[2] * a[7]);
      c[2] = a[1] * a[5] - a[2] * a[4];
      c[3] = -(a[3] * a[8] - a[5] * a[6]);
      c[4] = a[0] * a[8] - a[2] * a[6];
      c[5] = -(a[0] * a[5] - a[2] * a[3]);
      c[6] = a[3] * a[7] - a[4] * a[6];
      c[7] = -(a[0] * a[7] - a[1] * a[6]);
      c[8] = a[0] * a[4] - a[1] * a[3];
      det = wrap27(a[0] * c[0] + a[1] * c[3] + a[2] * c[6]);
      // A singular key falls back to a factor of minus one.
      dinv = 26;
      inv_missing = 1'b1;
      for (int i = 1; i < 27; i++) begin
        if ((det * i) % 27 == 1) begin
          dinv = i;
          inv_missing = 1'b0;
          break;
        end
      end
      for (int i = 0; i < 9; i++) inv_key[i] = 5'((wrap27(c[i]) * dinv) % 27);
    endfunction

    function void set_register(cfg_reg_t idx, logic [KEY_W-1:0] data);
      if (idx == REG_KEY) begin
        key = data;
        rebuild_inverse();
      end else begin
        decrypt = data[0];
      end
    endfunction

    function void push_block(int v0, int v1, int v2, logic eom);
      int v[3];
      int sum;
      int m;
      cipher_char_t e;
      v[0] = v0;
      v[1] = v1;
      v[2] = v2;
      for (int i = 0; i < 3; i++) begin
        sum = 0;
        for (int j = 0; j < 3; j++) begin
          m = decrypt ? int'(inv_key[3*i+j]) : entry(3*i+j);
          sum += m * v[j];
        end
        sum = sum % 27;
        e.ch = (sum == 0) ? 8'd32 : 8'(64 + sum);
        e.last = eom && (i == 2);
        e.bad_key = inv_missing;
        expected_chars.push_back(e);
      end
    endfunction

    function void note_byte(logic [7:0] b, logic eom);
      int code;
      code = letter_code(b);
      if (code >= 0) begin
        if (held_n == 2) begin
          push_block(held[0], held[1], code, eom);
          held_n = 0;
          return;
        end
        held[held_n] = 5'(code);
        held_n++;
      end
      if (eom && held_n != 0) begin
        push_block(held[0], (held_n >= 2) ? int'(held[1]) : int'(PAD_CODE),
                   int'(PAD_CODE), 1'b1);
        held_n = 0;
      end
    endfunction

    function void check_char(logic [7:0] ch, logic last, logic bad_key);
      cipher_char_t e;
      if (expected_chars.size() == 0) begin
        fail_count++;
        if (fail_count <= 10)
          $display("unexpected character %0d last %0b invalid %0b", ch, last, bad_key);
        return;
      end
      e = expected_chars.pop_front();
      if (e.ch !== ch || e.last !== last || e.bad_key !== bad_key) begin
        fail_count++;
        if (fail_count <= 10)
          $display("mismatch: expected char %0d last %0b invalid %0b, got %0d %0b %0b",
                   e.ch, e.last, e.bad_key, ch, last, bad_key);
      end
    endfunction

    function int chars_owed();
      return expected_chars.size();
    endfunction
  endclass

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             in_valid = 1'b0;
  logic             in_ready;
  logic [7:0]       text_byte = '0;
  logic             end_of_message = 1'b0;
  logic             out_valid;
  logic             out_ready = 1'b0;
  logic [7:0]       out_char;
  logic             last_of_message;
  logic             key_invalid;
  logic             cfg_valid = 1'b0;
  logic             cfg_ready;
  cfg_reg_t         cfg_index = REG_KEY;
  logic [KEY_W-1:0] cfg_data = '0;

  cipher_tracker tracker;
  bit            calm = 1'b0;
  int            stall_left = 0;
  int unsigned   cycles = 0;

  hill_cipher_3x3_mod27 dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .text_byte(text_byte),
    .end_of_message(end_of_message),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_char(out_char),
    .last_of_message(last_of_message),
    .key_invalid(key_invalid),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      tracker.check_char(out_char, last_of_message, key_invalid);
    end
    if (rst || calm) begin
      out_ready <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      out_ready <= 1'b0;
    end else if ($urandom_range(0, 4) == 0) begin
      stall_left = $urandom_range(0, 4);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  task automatic send_byte(logic [7:0] b, logic eom);
    int gap;
    gap = (!calm && $urandom_range(0, 3) == 0) ? $urandom_range(1, 5) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    text_byte <= b;
    end_of_message <= eom;
    do @(posedge clk); while (!in_ready);
    tracker.note_byte(b, eom);
  endtask

  task automatic send_text(string s, logic eom_last);
    for (int i = 0; i < s.len(); i++) begin
      send_byte(s[i], eom_last && (i == s.len() - 1));
    end
  endtask

  // Lower the request line and wait until every predicted character is back.
  task automatic settle();
    in_valid <= 1'b0;
    while (tracker.chars_owed() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(cfg_reg_t idx, logic [KEY_W-1:0] data, bit hold);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    tracker.set_register(idx, data);
    if (!hold) cfg_valid <= 1'b0;
  endtask

  function automatic logic [7:0] pick_letter();
    case ($urandom_range(0, 4))
      0: return 8'd32;
      1, 2: return 8'($urandom_range(65, 90));
      default: return 8'($urandom_range(97, 122));
    endcase
  endfunction

  function automatic logic [KEY_W-1:0] random_key();
    logic [KEY_W-1:0] k;
    k = '0;
    for (int n = 0; n < 9; n++) begin
      k[5*n +: 5] = ($urandom_range(0, 4) == 0) ? 5'($urandom_range(0, 31))
                                                : 5'($urandom_range(0, 26));
    end
    return k;
  endfunction

  initial begin
    int counted;
    logic [7:0] b;
    logic eom;
    tracker = new();
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Reset key, encrypt: extremes of the byte, dropped bytes and padding.
    send_text(" Az", 1'b0);
    send_text("Za", 1'b0);
    send_byte(8'd64, 1'b0);
    send_byte(8'd91, 1'b0);
    send_byte(8'd96, 1'b0);
    send_byte(8'd123, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_text(" ", 1'b0);
    send_text("Q", 1'b1);
    send_text("MN", 1'b1);
    send_byte(8'h7F, 1'b1);
    send_text("BCD", 1'b1);
    send_text("E!", 1'b1);
    settle();

    // Mode and key changes; the first key change comes with two codes held inside a block.
    cfg_write(REG_MODE, 45'd1, 1'b0);
    send_text("HI", 1'b0);
    settle();
    cfg_write(REG_KEY, '0, 1'b0);
    send_text("J", 1'b0);
    send_text("k", 1'b1);
    settle();
    cfg_write(REG_KEY, KEY_ALL_ONES, 1'b1);
    cfg_write(REG_MODE, 45'd0, 1'b0);
    send_text("yZ", 1'b1);
    settle();
    cfg_write(REG_MODE, 45'd1, 1'b0);
    send_text("wv u", 1'b1);
    settle();

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      if (p == RANDOM_PHASES - 1) calm = 1'b1;
      cfg_write(REG_KEY, (p == 0) ? KEY_RESET : random_key(), 1'b1);
      cfg_write(REG_MODE, KEY_W'($urandom_range(0, 1)), 1'b0);
      counted = 0;
      while (counted < PHASE_ITEMS) begin
        b = ($urandom_range(0, 6) == 0) ? 8'($urandom_range(0, 255)) : pick_letter();
        eom = ($urandom_range(0, 9) == 0);
        counted++;
        send_byte(b, eom);
      end
      settle();
    end

    if (tracker.fail_count == 0 && tracker.chars_owed() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

[files.f]
rtl/hill27_pkg.sv
rtl/hill_cipher_3x3_mod27.sv
tb/sv/tb_hill_cipher_3x3_mod27.sv
